// File: sv/tvt_pkg.sv
`timescale 1ns / 1ps
package tvt_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ISQRT_STEPS       = 16;
    localparam int GUARD_BITS        = 14;
    localparam int CW                = 34;   // CORDIC datapath width
    localparam logic [31:0] PHASE_SCALE = 32'd2734261102;
    localparam logic [29:0] INV_GAIN    = 30'd652032874;
    localparam logic [15:0] RATE_RESET  = 16'sd12288;

    typedef struct packed {
        logic [31:0]        ph;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } tvt_item_t;

    // Arctangent of 2^-i in binary-angle units (2^32 is a full turn).
    function automatic logic [31:0] tvt_atan(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            5'd31: a = 32'h00000000;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: sv/tvt_front.sv
`timescale 1ns / 1ps
module tvt_front
    import tvt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] rate,
    output logic               out_valid,
    input  logic               out_ready,
    output tvt_item_t          out_item
);

    // Stage 0 squares, stages 1..16 take one root bit each, then the angle
    // product, the two phase partial products and their sum.
    localparam int SQ  = ISQRT_STEPS;
    localparam int FS  = SQ + 4;

    logic [FS-1:0]      valid_reg;
    logic signed [15:0] x_reg [0:FS-1];
    logic signed [15:0] y_reg [0:FS-1];
    logic [31:0]        n_reg [0:SQ];
    logic [31:0]        root_reg [0:SQ];
    logic signed [32:0] ang_reg;
    logic signed [49:0] phhi_reg;
    logic [47:0]        phlo_reg;
    logic [31:0]        ph_reg;
    logic               en;
    logic [63:0]        ph_sum;

    assign en       = !valid_reg[FS-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[FS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= in_x;
            y_reg[0] <= in_y;
            n_reg[0] <= 32'(in_x * in_x) + 32'(in_y * in_y);
            root_reg[0] <= '0;
            for (int s = 1; s < FS; s++) begin
                x_reg[s] <= x_reg[s-1];
                y_reg[s] <= y_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_isqrt
        logic [31:0] bitv;
        logic [31:0] trial;
        assign bitv  = 32'h1 << (30 - 2 * k);
        assign trial = root_reg[k] + bitv;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (n_reg[k] >= trial) begin
                    n_reg[k+1]    <= n_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + bitv;
                end else begin
                    n_reg[k+1]    <= n_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    // The phase product is split at bit 16 of the angle to keep each
    // multiplier near 32 bits.
    assign ph_sum = {{14{phhi_reg[49]}}, phhi_reg} * 64'h10000 + {16'd0, phlo_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg  <= rate * $signed({1'b0, root_reg[SQ][15:0]});
            phhi_reg <= $signed(ang_reg[32:16]) * $signed({1'b0, PHASE_SCALE});
            phlo_reg <= ang_reg[15:0] * PHASE_SCALE;
            ph_reg   <= ph_sum[59:28];
        end
    end

    assign out_valid   = valid_reg[FS-1];
    assign out_item.ph = ph_reg;
    assign out_item.x  = x_reg[FS-1];
    assign out_item.y  = y_reg[FS-1];

endmodule

// File: sv/tvt_queue.sv
`timescale 1ns / 1ps
module tvt_queue
    import tvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  tvt_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output tvt_item_t pop_item
);

    tvt_item_t  mem_reg [0:3];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign push_ready = cnt_reg != 3'd4;
    assign pop_valid  = cnt_reg != 3'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

endmodule

// File: sv/tvt_back.sv
`timescale 1ns / 1ps
module tvt_back
    import tvt_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tvt_item_t          in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic               out_clip
);

    localparam int N = CORDIC_STAGES;

    logic [N+1:0]         valid_reg;
    logic signed [CW-1:0] cx_reg [0:N];
    logic signed [CW-1:0] cy_reg [0:N];
    logic signed [CW-1:0] cz_reg [0:N];
    logic signed [64:0]   px_reg, py_reg;
    logic                 en;
    logic                 fold;
    logic [31:0]          phf;
    logic signed [CW-1:0] xe, ye;
    logic signed [64:0]   rx_full, ry_full;
    logic signed [20:0]   rx, ry;
    logic                 clip_x, clip_y;
    logic                 m_valid_reg;
    logic signed [15:0]   m_x_reg, m_y_reg;
    logic                 m_clip_reg;

    assign en       = !m_valid_reg || out_ready;
    assign in_ready = en;

    // Phases in the left half-plane are turned by half a revolution.
    assign fold = in_item.ph[31] ^ in_item.ph[30];
    assign phf  = fold ? (in_item.ph ^ 32'h8000_0000) : in_item.ph;
    assign xe   = fold ? -CW'(in_item.x) : CW'(in_item.x);
    assign ye   = fold ? -CW'(in_item.y) : CW'(in_item.y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= xe <<< GUARD_BITS;
            cy_reg[0] <= ye <<< GUARD_BITS;
            cz_reg[0] <= CW'($signed(phf));
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CW-1:0] xs, ys, a;
        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;
        assign a  = CW'(tvt_atan(5'(i)));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!cz_reg[i][CW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - a;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + a;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= 65'(cx_reg[N] * $signed({1'b0, INV_GAIN}));
            py_reg <= 65'(cy_reg[N] * $signed({1'b0, INV_GAIN}));
        end
    end

    assign rx_full = (px_reg + (65'sd1 <<< 43)) >>> 44;
    assign ry_full = (py_reg + (65'sd1 <<< 43)) >>> 44;
    assign rx      = rx_full[20:0];
    assign ry      = ry_full[20:0];
    assign clip_x  = (rx > 21'sd32767) || (rx < -21'sd32768);
    assign clip_y  = (ry > 21'sd32767) || (ry < -21'sd32768);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_reg[N+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_x_reg    <= clip_x ? (rx[20] ? 16'sh8000 : 16'sh7FFF) : rx[15:0];
            m_y_reg    <= clip_y ? (ry[20] ? 16'sh8000 : 16'sh7FFF) : ry[15:0];
            m_clip_reg <= clip_x || clip_y;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_x     = m_x_reg;
    assign out_y     = m_y_reg;
    assign out_clip  = m_clip_reg;

endmodule

// File: sv/twist_vertex_transform_core.sv
`timescale 1ns / 1ps
// Throughput: one vertex per cycle while m_tready does not stall the output;
// the square root, the phase multipliers and the CORDIC rotation are each fully
// pipelined, one stage per root bit or rotation.
// A four-entry queue sits between the distance/phase front end and the rotation back end.
// Reset (aresetn low, synchronous) empties the pipelines and sets twist_rate to 3.0.
module twist_vertex_transform_core
    import tvt_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // in_x [15:0], in_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_x [15:0], out_y [31:16]
    output logic        m_tuser,    // clipped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] rate_reg;
    tvt_item_t          f_item, b_item;
    logic               f_valid, f_ready, b_valid, b_ready;
    logic signed [15:0] ox, oy;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, rate_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            rate_reg <= pwdata[15:0];
        end
    end

    tvt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .rate      (rate_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    tvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    tvt_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_item   (b_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (ox),
        .out_y     (oy),
        .out_clip  (m_tuser)
    );

    assign m_tdata = {oy, ox};

endmodule
